FILE: rtl/v2alu_pkg.sv
// ----------------------------------------------------------------------------
// v2alu_pkg
// Shared types, codes and helpers for the two-dimensional vector unit.
// ----------------------------------------------------------------------------
package v2alu_pkg;

  // Fraction bits of the Q format.
  localparam int FRAC = 16;

  // Radicand width and pipeline depths of the square root and the divider.
  localparam int RAD_W = 66;
  localparam int SQN   = RAD_W / 2;
  localparam int DVN   = 32;

  // Operation codes.
  localparam logic [4:0] MODE_ADD   = 5'd0;
  localparam logic [4:0] MODE_SUB   = 5'd1;
  localparam logic [4:0] MODE_SCALE = 5'd2;
  localparam logic [4:0] MODE_DIV   = 5'd3;
  localparam logic [4:0] MODE_DOT   = 5'd4;
  localparam logic [4:0] MODE_SQMAG = 5'd5;
  localparam logic [4:0] MODE_MAG   = 5'd6;
  localparam logic [4:0] MODE_DIST  = 5'd7;
  localparam logic [4:0] MODE_NORM  = 5'd8;
  localparam logic [4:0] MODE_CLAMP = 5'd9;
  localparam logic [4:0] MODE_MOVE  = 5'd10;
  localparam logic [4:0] MODE_LERPC = 5'd11;
  localparam logic [4:0] MODE_LERP  = 5'd12;
  localparam logic [4:0] MODE_REFL  = 5'd13;
  localparam logic [4:0] MODE_PERP  = 5'd14;
  localparam logic [4:0] MODE_MIN   = 5'd15;
  localparam logic [4:0] MODE_MAX   = 5'd16;

  typedef logic signed [31:0] q_t;

  localparam q_t ONE_Q = q_t'(1) <<< FRAC;
  localparam logic signed [67:0] SAT_BIG = 68'sd1 <<< 40;

  typedef struct packed {
    logic [4:0] mode;
    q_t         ax;
    q_t         ay;
    q_t         bx;
    q_t         by;
    q_t         s;
  } base_t;

  // Payload that rides along the square root pipeline.
  typedef struct packed {
    logic [4:0]         mode;
    q_t                 ax;
    q_t                 ay;
    q_t                 bx;
    q_t                 by;
    q_t                 s;
    logic signed [65:0] numx;
    logic signed [65:0] numy;
    q_t                 drx;
    q_t                 dry;
    logic               dflag;
  } carry_t;

  // One step of the digit-by-digit square root.
  typedef struct packed {
    logic [35:0]      rem;
    logic [32:0]      root;
    logic [RAD_W-1:0] rad;
  } sq_t;

  // Payload that rides along the divider pipeline.
  typedef struct packed {
    logic [4:0]  mode;
    q_t          ax;
    q_t          ay;
    q_t          bx;
    q_t          by;
    q_t          drx;
    q_t          dry;
    logic        dflag;
    logic [32:0] m;
    logic [32:0] d;
    logic        use_div;
    logic        ovx;
    logic        ovy;
    logic        negx;
    logic        negy;
  } fin_t;

  // One step of the restoring divider.
  typedef struct packed {
    logic [32:0] r;
    logic [31:0] nlo;
    logic [31:0] q;
  } dv_t;

  typedef struct packed {
    logic flag;
    q_t   val;
  } sat_t;

  // Clamp a wide value to the 32-bit signed range.
  function automatic sat_t sat32(input logic signed [67:0] v);
    sat_t o;
    if (v > 68'sh7FFFFFFF) begin
      o.flag = 1'b1;
      o.val  = 32'sh7FFFFFFF;
    end else if (v < -68'sh80000000) begin
      o.flag = 1'b1;
      o.val  = 32'sh80000000;
    end else begin
      o.flag = 1'b0;
      o.val  = 32'(v);
    end
    return o;
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return (v < 0) ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [65:0] abs66(input logic signed [65:0] v);
    return (v < 0) ? 66'(-v) : 66'(v);
  endfunction

endpackage

FILE: rtl/v2alu_in_if.sv
// ----------------------------------------------------------------------------
// v2alu_in_if
// Input channel of the vector unit: two vectors, a scalar and a mode.
// ----------------------------------------------------------------------------
interface v2alu_in_if;
  logic              valid;
  logic              ready;
  logic [4:0]        mode;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] scalar_in;

  modport source (output valid, mode, a_x, a_y, b_x, b_y, scalar_in, input ready);
  modport sink (input valid, mode, a_x, a_y, b_x, b_y, scalar_in, output ready);
endinterface

FILE: rtl/v2alu_out_if.sv
// ----------------------------------------------------------------------------
// v2alu_out_if
// Result channel of the vector unit: one vector or scalar and a flag.
// ----------------------------------------------------------------------------
interface v2alu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic               saturated;

  modport source (output valid, result_x, result_y, saturated, input ready);
  modport sink (input valid, result_x, result_y, saturated, output ready);
endinterface

FILE: rtl/vector2_fixed_point_alu.sv
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// The depth is set by the 33-stage square root and the 32-stage divider.
// Reset clears only the valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// vector2_fixed_point_alu
// Pipelined Q16.16 two-dimensional vector unit with saturating results.
// ----------------------------------------------------------------------------
module vector2_fixed_point_alu import v2alu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  v2alu_in_if.sink  in_ch,
  v2alu_out_if.source out_ch
);

  logic adv;
  logic out_valid_r;
  logic v0_r, v1_r, v2_r, v3_r;
  logic [SQN:0] sqv_r;
  logic [DVN:0] dvv_r;

  // The pipeline moves whenever the output register is free or drained.
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_valid_r;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      sqv_r <= '0;
      dvv_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      sqv_r <= {sqv_r[SQN-1:0], v3_r};
      dvv_r <= {dvv_r[DVN-1:0], sqv_r[SQN]};
      out_valid_r <= dvv_r[DVN];
    end
  end

  // Stage 0: capture the item, form b - a and the lerp fraction.
  base_t b0_r, b0_nxt;
  logic signed [32:0] dx0_r, dy0_r, dx0_nxt, dy0_nxt;
  q_t t0_r, t0_nxt;

  always_comb begin
    b0_nxt.mode = in_ch.mode;
    b0_nxt.ax = in_ch.a_x;
    b0_nxt.ay = in_ch.a_y;
    b0_nxt.bx = in_ch.b_x;
    b0_nxt.by = in_ch.b_y;
    b0_nxt.s = in_ch.scalar_in;
    dx0_nxt = 33'(in_ch.b_x) - 33'(in_ch.a_x);
    dy0_nxt = 33'(in_ch.b_y) - 33'(in_ch.a_y);
    t0_nxt = in_ch.scalar_in;
    if (in_ch.mode == MODE_LERPC) begin
      if (in_ch.scalar_in < 0) begin
        t0_nxt = '0;
      end else if (in_ch.scalar_in > ONE_Q) begin
        t0_nxt = ONE_Q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_r <= b0_nxt;
      dx0_r <= dx0_nxt;
      dy0_r <= dy0_nxt;
      t0_r <= t0_nxt;
    end
  end

  // Stage 1: the two component products and the two squares.
  base_t b1_r;
  logic signed [65:0] px1_r, py1_r, px1_nxt, py1_nxt;
  logic [65:0] sqx1_r, sqy1_r, sqx1_nxt, sqy1_nxt;
  logic signed [32:0] opxa, opxb, opya, opyb;
  logic [32:0] ux, uy;

  always_comb begin
    opxa = 33'(b0_r.ax);
    opxb = 33'(b0_r.bx);
    opya = 33'(b0_r.ay);
    opyb = 33'(b0_r.by);
    unique case (b0_r.mode)
      MODE_SCALE, MODE_CLAMP: begin
        opxb = 33'(b0_r.s);
        opyb = 33'(b0_r.s);
      end
      MODE_SQMAG: begin
        opxb = 33'(b0_r.ax);
        opyb = 33'(b0_r.ay);
      end
      MODE_MOVE: begin
        opxa = dx0_r;
        opya = dy0_r;
        opxb = 33'(b0_r.s);
        opyb = 33'(b0_r.s);
      end
      MODE_LERPC, MODE_LERP: begin
        opxa = dx0_r;
        opya = dy0_r;
        opxb = 33'(t0_r);
        opyb = 33'(t0_r);
      end
      default: begin
      end
    endcase
    if (b0_r.mode == MODE_DIST || b0_r.mode == MODE_MOVE) begin
      ux = abs33(dx0_r);
      uy = abs33(dy0_r);
    end else begin
      ux = abs33(33'(b0_r.ax));
      uy = abs33(33'(b0_r.ay));
    end
    px1_nxt = 66'(opxa) * 66'(opxb);
    py1_nxt = 66'(opya) * 66'(opyb);
    sqx1_nxt = 66'(ux) * 66'(ux);
    sqy1_nxt = 66'(uy) * 66'(uy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r <= b0_r;
      px1_r <= px1_nxt;
      py1_r <= py1_nxt;
      sqx1_r <= sqx1_nxt;
      sqy1_r <= sqy1_nxt;
    end
  end

  // Stage 2: dot product, clamped dot, radicand and division numerators.
  base_t b2_r;
  logic signed [50:0] dot2_r, dot2_nxt;
  q_t k2_r;
  logic kf2_r;
  logic signed [49:0] lx2_r, ly2_r, lx2_nxt, ly2_nxt;
  logic [RAD_W-1:0] rad2_r, rad2_nxt;
  logic signed [65:0] numx2_r, numy2_r, numx2_nxt, numy2_nxt;
  logic signed [66:0] sum2;
  sat_t ks2;

  always_comb begin
    sum2 = 67'(px1_r) + 67'(py1_r);
    dot2_nxt = 51'(sum2 >>> FRAC);
    ks2 = sat32(68'(dot2_nxt));
    lx2_nxt = 50'(px1_r >>> FRAC);
    ly2_nxt = 50'(py1_r >>> FRAC);
    rad2_nxt = sqx1_r + sqy1_r;
    if (b1_r.mode == MODE_CLAMP || b1_r.mode == MODE_MOVE) begin
      numx2_nxt = px1_r;
      numy2_nxt = py1_r;
    end else begin
      numx2_nxt = 66'(b1_r.ax) <<< FRAC;
      numy2_nxt = 66'(b1_r.ay) <<< FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_r <= b1_r;
      dot2_r <= dot2_nxt;
      k2_r <= ks2.val;
      kf2_r <= ks2.flag;
      lx2_r <= lx2_nxt;
      ly2_r <= ly2_nxt;
      rad2_r <= rad2_nxt;
      numx2_r <= numx2_nxt;
      numy2_r <= numy2_nxt;
    end
  end

  // Stage 3: reflection products of the clamped dot with b.
  base_t b3_r;
  logic signed [50:0] dot3_r;
  logic kf3_r;
  logic signed [49:0] lx3_r, ly3_r;
  logic [RAD_W-1:0] rad3_r;
  logic signed [65:0] numx3_r, numy3_r;
  logic signed [63:0] kbx3_r, kby3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_r <= b2_r;
      dot3_r <= dot2_r;
      kf3_r <= kf2_r;
      lx3_r <= lx2_r;
      ly3_r <= ly2_r;
      rad3_r <= rad2_r;
      numx3_r <= numx2_r;
      numy3_r <= numy2_r;
      kbx3_r <= 64'(k2_r) * 64'(b2_r.bx);
      kby3_r <= 64'(k2_r) * 64'(b2_r.by);
    end
  end

  // Stage 4: results that need neither the root nor the divider.
  carry_t c_r [0:SQN];
  sq_t sq_r [0:SQN];
  carry_t c4_nxt;
  logic signed [67:0] wx, wy;
  sat_t sx4, sy4;

  always_comb begin
    wx = '0;
    wy = '0;
    unique case (b3_r.mode)
      MODE_ADD: begin
        wx = 68'(b3_r.ax) + 68'(b3_r.bx);
        wy = 68'(b3_r.ay) + 68'(b3_r.by);
      end
      MODE_SUB: begin
        wx = 68'(b3_r.ax) - 68'(b3_r.bx);
        wy = 68'(b3_r.ay) - 68'(b3_r.by);
      end
      MODE_SCALE: begin
        wx = 68'(lx3_r);
        wy = 68'(ly3_r);
      end
      MODE_DOT, MODE_SQMAG: begin
        wx = 68'(dot3_r);
      end
      MODE_LERPC, MODE_LERP: begin
        wx = 68'(b3_r.ax) + 68'(lx3_r);
        wy = 68'(b3_r.ay) + 68'(ly3_r);
      end
      MODE_REFL: begin
        wx = 68'(b3_r.ax) - 68'(kbx3_r >>> (FRAC - 1));
        wy = 68'(b3_r.ay) - 68'(kby3_r >>> (FRAC - 1));
      end
      MODE_PERP: begin
        wx = -68'(b3_r.ay);
        wy = 68'(b3_r.ax);
      end
      MODE_MIN: begin
        wx = 68'((b3_r.ax < b3_r.bx) ? b3_r.ax : b3_r.bx);
        wy = 68'((b3_r.ay < b3_r.by) ? b3_r.ay : b3_r.by);
      end
      MODE_MAX: begin
        wx = 68'((b3_r.ax > b3_r.bx) ? b3_r.ax : b3_r.bx);
        wy = 68'((b3_r.ay > b3_r.by) ? b3_r.ay : b3_r.by);
      end
      default: begin
      end
    endcase
    sx4 = sat32(wx);
    sy4 = sat32(wy);
    c4_nxt.mode = b3_r.mode;
    c4_nxt.ax = b3_r.ax;
    c4_nxt.ay = b3_r.ay;
    c4_nxt.bx = b3_r.bx;
    c4_nxt.by = b3_r.by;
    c4_nxt.s = b3_r.s;
    c4_nxt.numx = numx3_r;
    c4_nxt.numy = numy3_r;
    c4_nxt.drx = sx4.val;
    c4_nxt.dry = sy4.val;
    c4_nxt.dflag = sx4.flag | sy4.flag | ((b3_r.mode == MODE_REFL) & kf3_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0] <= c4_nxt;
      sq_r[0].rem <= '0;
      sq_r[0].root <= '0;
      sq_r[0].rad <= rad3_r;
    end
  end

  // Square root: one root bit per stage, two radicand bits shifted in each.
  for (genvar i = 0; i < SQN; i++) begin : g_sqrt
    sq_t sq_nxt;
    logic [37:0] remx;
    logic [37:0] trial;

    always_comb begin
      remx = {sq_r[i].rem, sq_r[i].rad[RAD_W-1 -: 2]};
      trial = 38'({sq_r[i].root, 2'b01});
      sq_nxt.rad = sq_r[i].rad << 2;
      if (remx >= trial) begin
        sq_nxt.rem = 36'(remx - trial);
        sq_nxt.root = {sq_r[i].root[31:0], 1'b1};
      end else begin
        sq_nxt.rem = remx[35:0];
        sq_nxt.root = {sq_r[i].root[31:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[i+1] <= sq_nxt;
        c_r[i+1] <= c_r[i];
      end
    end
  end

  // Divider setup: pick divisor, signs, magnitudes and the overflow check.
  fin_t f_r [0:DVN];
  dv_t dvx_r [0:DVN];
  dv_t dvy_r [0:DVN];
  fin_t f0_nxt;
  dv_t dvx0_nxt, dvy0_nxt;
  carry_t cs;
  logic [32:0] mroot;
  logic [65:0] magx, magy;
  logic signed [33:0] m_s, s_s;

  always_comb begin
    cs = c_r[SQN];
    mroot = sq_r[SQN].root;
    m_s = 34'(mroot);
    s_s = 34'(cs.s);
    magx = abs66(cs.numx);
    magy = abs66(cs.numy);
    f0_nxt.mode = cs.mode;
    f0_nxt.ax = cs.ax;
    f0_nxt.ay = cs.ay;
    f0_nxt.bx = cs.bx;
    f0_nxt.by = cs.by;
    f0_nxt.drx = cs.drx;
    f0_nxt.dry = cs.dry;
    f0_nxt.dflag = cs.dflag;
    f0_nxt.m = mroot;
    f0_nxt.d = mroot;
    f0_nxt.negx = cs.numx < 0;
    f0_nxt.negy = cs.numy < 0;
    unique case (cs.mode)
      MODE_DIV: begin
        f0_nxt.d = abs33(33'(cs.s));
        f0_nxt.use_div = cs.s != 0;
        f0_nxt.negx = (cs.numx < 0) ^ (cs.s < 0);
        f0_nxt.negy = (cs.numy < 0) ^ (cs.s < 0);
      end
      MODE_NORM: f0_nxt.use_div = mroot != '0;
      MODE_CLAMP: f0_nxt.use_div = (mroot != '0) && (m_s > s_s);
      MODE_MOVE: f0_nxt.use_div = !((mroot == '0) || (m_s <= s_s));
      default: f0_nxt.use_div = 1'b0;
    endcase
    f0_nxt.ovx = magx[65:32] >= 34'(f0_nxt.d);
    f0_nxt.ovy = magy[65:32] >= 34'(f0_nxt.d);
    dvx0_nxt.r = magx[64:32];
    dvx0_nxt.nlo = magx[31:0];
    dvx0_nxt.q = '0;
    dvy0_nxt.r = magy[64:32];
    dvy0_nxt.nlo = magy[31:0];
    dvy0_nxt.q = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[0] <= f0_nxt;
      dvx_r[0] <= dvx0_nxt;
      dvy_r[0] <= dvy0_nxt;
    end
  end

  // Restoring divider: one quotient bit per stage for each component.
  for (genvar j = 0; j < DVN; j++) begin : g_div
    dv_t dx_nxt, dy_nxt;
    logic [33:0] rx, ry, dd;

    always_comb begin
      dd = 34'(f_r[j].d);
      rx = {dvx_r[j].r, dvx_r[j].nlo[31]};
      ry = {dvy_r[j].r, dvy_r[j].nlo[31]};
      dx_nxt.nlo = dvx_r[j].nlo << 1;
      dy_nxt.nlo = dvy_r[j].nlo << 1;
      if (rx >= dd) begin
        dx_nxt.r = 33'(rx - dd);
        dx_nxt.q = {dvx_r[j].q[30:0], 1'b1};
      end else begin
        dx_nxt.r = rx[32:0];
        dx_nxt.q = {dvx_r[j].q[30:0], 1'b0};
      end
      if (ry >= dd) begin
        dy_nxt.r = 33'(ry - dd);
        dy_nxt.q = {dvy_r[j].q[30:0], 1'b1};
      end else begin
        dy_nxt.r = ry[32:0];
        dy_nxt.q = {dvy_r[j].q[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        f_r[j+1] <= f_r[j];
        dvx_r[j+1] <= dx_nxt;
        dvy_r[j+1] <= dy_nxt;
      end
    end
  end

  // Final stage: signed quotients, mode select and saturation.
  fin_t ff;
  logic signed [67:0] qx, qy, fx, fy;
  sat_t ox, oy;
  q_t out_x_r, out_y_r;
  logic out_sat_r;

  always_comb begin
    ff = f_r[DVN];
    qx = $signed(68'(dvx_r[DVN].q));
    qy = $signed(68'(dvy_r[DVN].q));
    if (ff.negx) qx = -qx;
    if (ff.negy) qy = -qy;
    if (ff.ovx) qx = ff.negx ? -SAT_BIG : SAT_BIG;
    if (ff.ovy) qy = ff.negy ? -SAT_BIG : SAT_BIG;
    fx = 68'(ff.drx);
    fy = 68'(ff.dry);
    unique case (ff.mode)
      MODE_MAG, MODE_DIST: begin
        fx = $signed(68'(ff.m));
        fy = '0;
      end
      MODE_DIV, MODE_NORM: begin
        fx = ff.use_div ? qx : '0;
        fy = ff.use_div ? qy : '0;
      end
      MODE_CLAMP: begin
        fx = ff.use_div ? qx : 68'(ff.ax);
        fy = ff.use_div ? qy : 68'(ff.ay);
      end
      MODE_MOVE: begin
        fx = ff.use_div ? 68'(ff.ax) + qx : 68'(ff.bx);
        fy = ff.use_div ? 68'(ff.ay) + qy : 68'(ff.by);
      end
      default: begin
      end
    endcase
    ox = sat32(fx);
    oy = sat32(fy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= ox.val;
      out_y_r <= oy.val;
      out_sat_r <= ox.flag | oy.flag | ff.dflag;
    end
  end

  assign out_ch.result_x = out_x_r;
  assign out_ch.result_y = out_y_r;
  assign out_ch.saturated = out_sat_r;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives item streams through the Q16.16 vector unit and checks every result.
// A local predictor computes the expected vector, scalar and saturation flag
// with wide integer arithmetic. Each result is compared in order against
// the predictions. Phases vary idling on both channels and include a long
// receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module testbench import v2alu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic [4:0] mode;
    q_t ax;
    q_t ay;
    q_t bx;
    q_t by;
    q_t s;
  } vec_op_t;

  typedef struct {
    q_t   rx;
    q_t   ry;
    logic sat;
  } vec_res_t;

  localparam q_t QMAX = 32'sh7FFFFFFF;
  localparam q_t QMIN = 32'sh80000000;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n;

  vec_res_t results_due[$];
  int       mismatches = 0;
  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;
  int       holdoff_request = 0;
  int       quiet_cycles = 0;

  v2alu_in_if  in_if();
  v2alu_out_if out_if();

  vector2_fixed_point_alu u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #1 clk = ~clk;

  // Clamp a wide value into the 32-bit range and note any clamp.
  function automatic q_t clip32(input wide_t v, inout logic flag);
    if (v > wide_t'(QMAX)) begin
      flag = 1'b1;
      return QMAX;
    end else if (v < wide_t'(QMIN)) begin
      flag = 1'b1;
      return QMIN;
    end
    return q_t'(v);
  endfunction

  // Floor integer square root, exact for radicands up to 2^66.
  function automatic wide_t floor_sqrt(input wide_t n);
    wide_t root;
    wide_t trial;
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (wide_t'(1) <<< b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Expected result of one item, computed without any intermediate overflow.
  function automatic vec_res_t vector_result(input vec_op_t it);
    wide_t    ax, ay, bx, by, s, rx, ry, dx, dy, m, t, k, one;
    logic     flag;
    vec_res_t r;
    ax = wide_t'(it.ax);
    ay = wide_t'(it.ay);
    bx = wide_t'(it.bx);
    by = wide_t'(it.by);
    s  = wide_t'(it.s);
    one = wide_t'(1) <<< FRAC;
    rx = 0;
    ry = 0;
    flag = 1'b0;
    case (it.mode)
      MODE_ADD: begin
        rx = ax + bx;
        ry = ay + by;
      end
      MODE_SUB: begin
        rx = ax - bx;
        ry = ay - by;
      end
      MODE_SCALE: begin
        rx = (ax * s) >>> FRAC;
        ry = (ay * s) >>> FRAC;
      end
      MODE_DIV: begin
        if (s != 0) begin
          rx = (ax <<< FRAC) / s;
          ry = (ay <<< FRAC) / s;
        end
      end
      MODE_DOT:   rx = (ax * bx + ay * by) >>> FRAC;
      MODE_SQMAG: rx = (ax * ax + ay * ay) >>> FRAC;
      MODE_MAG:   rx = floor_sqrt(ax * ax + ay * ay);
      MODE_DIST: begin
        dx = bx - ax;
        dy = by - ay;
        rx = floor_sqrt(dx * dx + dy * dy);
      end
      MODE_NORM: begin
        m = floor_sqrt(ax * ax + ay * ay);
        if (m != 0) begin
          rx = (ax <<< FRAC) / m;
          ry = (ay <<< FRAC) / m;
        end
      end
      MODE_CLAMP: begin
        m = floor_sqrt(ax * ax + ay * ay);
        if (m != 0 && m > s) begin
          rx = (ax * s) / m;
          ry = (ay * s) / m;
        end else begin
          rx = ax;
          ry = ay;
        end
      end
      MODE_MOVE: begin
        dx = bx - ax;
        dy = by - ay;
        m = floor_sqrt(dx * dx + dy * dy);
        if (m == 0 || m <= s) begin
          rx = bx;
          ry = by;
        end else begin
          rx = ax + (dx * s) / m;
          ry = ay + (dy * s) / m;
        end
      end
      MODE_LERPC, MODE_LERP: begin
        t = s;
        if (it.mode == MODE_LERPC) begin
          if (t < 0) t = 0;
          if (t > one) t = one;
        end
        rx = ax + (((bx - ax) * t) >>> FRAC);
        ry = ay + (((by - ay) * t) >>> FRAC);
      end
      MODE_REFL: begin
        // The dot product is clamped first, which may already set the flag.
        k = wide_t'(clip32((ax * bx + ay * by) >>> FRAC, flag));
        rx = ax - ((k * bx) >>> (FRAC - 1));
        ry = ay - ((k * by) >>> (FRAC - 1));
      end
      MODE_PERP: begin
        rx = -ay;
        ry = ax;
      end
      MODE_MIN: begin
        rx = (ax < bx) ? ax : bx;
        ry = (ay < by) ? ay : by;
      end
      MODE_MAX: begin
        rx = (ax > bx) ? ax : bx;
        ry = (ay > by) ? ay : by;
      end
      default: ;
    endcase
    r.rx  = clip32(rx, flag);
    r.ry  = clip32(ry, flag);
    r.sat = flag;
    return r;
  endfunction

  function automatic vec_op_t make_op(input logic [4:0] mode, input q_t ax, input q_t ay,
                                      input q_t bx, input q_t by, input q_t s);
    vec_op_t it;
    it.mode = mode;
    it.ax = ax;
    it.ay = ay;
    it.bx = bx;
    it.by = by;
    it.s = s;
    return it;
  endfunction

  // Values mostly of moderate size, with full-range and edge values mixed in.
  function automatic q_t random_q();
    int unsigned pick;
    q_t v;
    pick = $urandom_range(9);
    v = q_t'($urandom);
    case (pick)
      0, 1, 2: return v;
      3, 4:    return v >>> 20;
      5, 6:    return v >>> 12;
      7:       return v >>> 26;
      default: begin
        case ($urandom_range(4))
          0: return QMAX;
          1: return QMIN;
          2: return 0;
          3: return 32'sh00010000;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic vec_op_t random_op();
    vec_op_t it;
    if ($urandom_range(9) == 0) it.mode = 5'($urandom_range(31, 17));
    else it.mode = 5'($urandom_range(16, 0));
    it.ax = random_q();
    it.ay = random_q();
    it.bx = random_q();
    it.by = random_q();
    it.s = random_q();
    // Keep many lerp fractions near the 0..1 window.
    if ((it.mode == MODE_LERPC || it.mode == MODE_LERP) && $urandom_range(1) == 1)
      it.s = q_t'($urandom_range(32'h30000)) - 32'sh8000;
    return it;
  endfunction

  // Send one item, with a random idle gap first; valid stays high on return.
  task automatic send_item(input vec_op_t it);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= it.mode;
    in_if.a_x       <= it.ax;
    in_if.a_y       <= it.ay;
    in_if.b_x       <= it.bx;
    in_if.b_y       <= it.by;
    in_if.scalar_in <= it.s;
    forever begin
      @(posedge clk);
      if (in_if.valid && in_if.ready) break;
    end
    results_due.push_back(vector_result(it));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(random_op());
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    vec_op_t ops[$];
    ops.push_back(make_op(MODE_ADD, QMAX, QMIN, 32'sd1, -32'sd1, 0));
    ops.push_back(make_op(MODE_SUB, QMIN, QMAX, 32'sd1, -32'sd1, 0));
    ops.push_back(make_op(MODE_SCALE, QMAX, QMIN, 0, 0, QMIN));
    ops.push_back(make_op(MODE_DIV, 32'sh30000, -32'sh20000, 0, 0, 0));
    ops.push_back(make_op(MODE_DIV, QMIN, QMAX, 0, 0, -32'sd1));
    ops.push_back(make_op(MODE_DOT, QMIN, QMIN, QMIN, QMIN, 0));
    ops.push_back(make_op(MODE_SQMAG, QMAX, QMIN, 0, 0, 0));
    ops.push_back(make_op(MODE_MAG, QMIN, QMIN, 0, 0, 0));
    ops.push_back(make_op(MODE_DIST, QMIN, QMIN, QMAX, QMAX, 0));
    ops.push_back(make_op(MODE_NORM, 0, 0, 0, 0, 0));
    ops.push_back(make_op(MODE_NORM, 32'sd1, 0, 0, 0, 0));
    ops.push_back(make_op(MODE_CLAMP, 0, 0, 0, 0, -32'sh10000));
    ops.push_back(make_op(MODE_CLAMP, 32'sh30000, 32'sh40000, 0, 0, -32'sh10000));
    ops.push_back(make_op(MODE_MOVE, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, QMIN));
    ops.push_back(make_op(MODE_MOVE, 0, 0, 32'sh30000, 32'sh40000, -32'sh10000));
    ops.push_back(make_op(MODE_LERPC, 0, 0, 32'sh10000, QMIN, -32'sh8000));
    ops.push_back(make_op(MODE_LERPC, QMIN, 0, QMAX, 32'sh10000, QMAX));
    ops.push_back(make_op(MODE_LERP, QMIN, QMAX, QMAX, QMIN, QMAX));
    ops.push_back(make_op(MODE_REFL, QMAX, QMAX, QMAX, QMAX, 0));
    ops.push_back(make_op(MODE_REFL, 32'sh10000, 0, 0, 32'sh10000, 0));
    ops.push_back(make_op(MODE_PERP, 32'sd5, QMIN, 0, 0, 0));
    ops.push_back(make_op(MODE_MIN, QMIN, QMAX, QMAX, QMIN, 0));
    ops.push_back(make_op(MODE_MAX, QMIN, QMAX, QMAX, QMIN, 0));
    ops.push_back(make_op(5'd17, QMAX, QMAX, QMAX, QMAX, QMAX));
    ops.push_back(make_op(5'd31, QMIN, QMIN, QMIN, QMIN, QMIN));
    foreach (ops[i]) send_item(ops[i]);
    wait_drained();
  endtask

  task automatic test_phase(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    send_random(count);
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering items.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    holdoff_request = 300;
    send_random(120);
    wait_drained();
  endtask

  // Sender pauses mid-stream until every result is back.
  task automatic test_drain_pause();
    sender_idle_pct = 22;
    receiver_stall_pct = 22;
    send_random(25);
    wait_drained();
    send_random(25);
    wait_drained();
  endtask

  // Receiver ready, with random stalls and requested hold-offs.
  initial begin
    int held;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_request > 0) begin
        held = holdoff_request;
        holdoff_request = 0;
        out_if.ready <= 1'b0;
        repeat (held - 1) @(posedge clk);
      end else begin
        out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    vec_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        $error("result with no item outstanding: x=%0d y=%0d", out_if.result_x,
               out_if.result_y);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_if.result_x !== want.rx) begin
          $error("result_x: expected %0d, got %0d", want.rx, out_if.result_x);
          mismatches++;
        end
        if (out_if.result_y !== want.ry) begin
          $error("result_y: expected %0d, got %0d", want.ry, out_if.result_y);
          mismatches++;
        end
        if (out_if.saturated !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, out_if.saturated);
          mismatches++;
        end
      end
    end
  end

  // Stop the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= '0;
    in_if.a_x       <= '0;
    in_if.a_y       <= '0;
    in_if.b_x       <= '0;
    in_if.b_y       <= '0;
    in_if.scalar_in <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_phase(0, 0, 150);
    test_phase(77, 0, 120);
    test_phase(0, 77, 120);
    test_phase(22, 22, 120);
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
